FILE: hw/rtl/knn_pkg.sv
// knn_pkg: shared types and constants of the k-nearest-neighbour classifier
// no dependencies; used by the interfaces and every rtl module
package knn_pkg;

   localparam int ATTR_BITS  = 16;
   localparam int LABEL_W    = 4;
   localparam int VOTE_W     = 5;
   localparam int OP_W       = 2;
   localparam int CFG_W      = 5;
   localparam int SQ_W       = 2 * ATTR_BITS;
   // 64 attributes of squares below 2^32 fit easily
   localparam int DIST_W     = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_TRAIN = 2'd1,
      OP_TEST  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_K       = 2'd0,
      REG_CLASSES = 2'd1,
      REG_ATTRS   = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } dist_ctl_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic               valid;
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
   } cell_data_type;

endpackage

FILE: hw/rtl/knn_if.sv
// knn_req_if and knn_rsp_if: valid/ready channels of the classifier
// depends on knn_pkg for field widths
interface knn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [knn_pkg::OP_W-1:0]             op;
   logic signed [knn_pkg::ATTR_BITS-1:0] attr_value;
   logic [knn_pkg::LABEL_W-1:0]          train_label;
   logic                                 is_last;
   modport source (output valid, op, attr_value, train_label, is_last, input ready);
   modport sink   (input valid, op, attr_value, train_label, is_last, output ready);
endinterface

interface knn_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [knn_pkg::LABEL_W-1:0] class_out;
   logic [knn_pkg::VOTE_W-1:0]  winning_votes;
   modport source (output valid, class_out, winning_votes, input ready);
   modport sink   (input valid, class_out, winning_votes, output ready);
endinterface

FILE: hw/rtl/knn_dist.sv
// knn_dist: subtract, square and accumulate pipeline for one distance
// depends on knn_pkg
module knn_dist (
   input  logic                                 clock,
   input  logic                                 reset,
   input  knn_pkg::dist_ctl_type                ctl_in,
   input  logic signed [knn_pkg::ATTR_BITS-1:0] train_val,
   input  logic signed [knn_pkg::ATTR_BITS-1:0] test_val,
   input  logic [knn_pkg::LABEL_W-1:0]          label_in,
   output logic                                 done,
   output logic [knn_pkg::DIST_W-1:0]           distance,
   output logic [knn_pkg::LABEL_W-1:0]          label_out
);
   logic signed [knn_pkg::ATTR_BITS:0]     diff;
   logic signed [2*knn_pkg::ATTR_BITS+1:0] prod;
   logic [knn_pkg::SQ_W-1:0]               sq_ff, sq_in;
   knn_pkg::dist_ctl_type                  ctl_ff;
   logic [knn_pkg::LABEL_W-1:0]            lab2_ff, lab3_ff;
   logic [knn_pkg::DIST_W-1:0]             acc_ff, acc_in;
   logic                                   done_ff, done_in;

   assign diff  = {train_val[knn_pkg::ATTR_BITS-1], train_val}
                - {test_val[knn_pkg::ATTR_BITS-1], test_val};
   assign prod  = diff * diff;
   assign sq_in = prod[knn_pkg::SQ_W-1:0];

   always_comb begin
      acc_in  = acc_ff;
      done_in = ctl_ff.valid & ctl_ff.last;
      if (ctl_ff.valid) begin
         if (ctl_ff.first) begin
            acc_in = knn_pkg::DIST_W'(sq_ff);
         end else begin
            acc_in = acc_ff + knn_pkg::DIST_W'(sq_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      lab2_ff <= label_in;
      lab3_ff <= lab2_ff;
      acc_ff  <= acc_in;
   end

   assign done      = done_ff;
   assign distance  = acc_ff;
   assign label_out = lab3_ff;
endmodule

FILE: hw/rtl/knn_cell.sv
// knn_cell: one place of the sorted nearest-neighbour chain
// depends on knn_pkg
module knn_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  knn_pkg::cell_ctl_type        ctl,
   input  logic                         enable,
   input  logic [knn_pkg::DIST_W-1:0]   ins_dist,
   input  logic [knn_pkg::LABEL_W-1:0]  ins_label,
   input  knn_pkg::cell_data_type       prev_data,
   input  logic                         prev_less,
   input  knn_pkg::cell_data_type       next_data,
   output knn_pkg::cell_data_type       data,
   output logic                         less
);
   knn_pkg::cell_data_type data_ff, data_in;

   // strict compare: an equal distance stays behind the earlier entry
   assign less = enable & (~data_ff.valid | (ins_dist < data_ff.distance));

   always_comb begin
      data_in = data_ff;
      if (ctl.clear) begin
         data_in.valid = 1'b0;
      end else if (ctl.insert && less) begin
         if (prev_less) begin
            data_in = prev_data;
         end else begin
            data_in.valid    = 1'b1;
            data_in.distance = ins_dist;
            data_in.label    = ins_label;
         end
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
endmodule

FILE: hw/rtl/knn_classifier.sv
// knn_classifier: top level of the k-nearest-neighbour classifier
// depends on knn_pkg, knn_if, knn_dist and knn_cell
//
// usage
//   req_chan carries one attribute per transaction: op clear, train, test or nop,
//   with is_last closing a vector (train_label taken with it). rsp_chan gives
//   one transaction per test vector: winning class and its vote count.
//   csr_* is an apb port: k_neighbors at 0x0, class_count at 0x4,
//   attribute_count at 0x8; pready is always high.
// throughput and sequence
//   clear, train and non-final test attributes are taken one per cycle, back
//   to back. the final test attribute starts a scan of the training store,
//   one memory read per cycle, then a pipeline drain, a shift of the
//   neighbour chain out for voting and a pass over the classes to pick the
//   winner; an empty store skips scan and drain. no new request is taken until
//   the result transaction has completed.
// reset
//   synchronous, active high: store empty, attribute index zero, registers
//   back to k=1, classes=2, attributes=1. memories are not cleared.
// stall
//   the result holds in its output register while rsp_chan.ready is low.
module knn_classifier #(
   parameter int MAX_TRAIN   = 1024,
   parameter int MAX_ATTR    = 16,
   parameter int MAX_K       = 16,
   parameter int MAX_CLASSES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   knn_req_if.sink                            req_chan,
   knn_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [knn_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [knn_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [knn_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   localparam int TV_DEPTH = MAX_TRAIN * MAX_ATTR;
   localparam int TV_AW    = (TV_DEPTH > 1) ? $clog2(TV_DEPTH) : 1;
   localparam int ENT_W    = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int CNT_W    = $clog2(MAX_TRAIN + 1);
   localparam int IDX_W    = (MAX_ATTR > 1) ? $clog2(MAX_ATTR) : 1;
   localparam int AEW      = $clog2(MAX_ATTR + 1);
   localparam int KEW      = $clog2(MAX_K + 1);
   localparam int KW       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CEW      = $clog2(MAX_CLASSES + 1);
   localparam int CLS_W    = $clog2(MAX_CLASSES);
   localparam int VCW      = $clog2(MAX_K + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_VOTE  = 6'b001000,
      ST_WIN   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [knn_pkg::CFG_W-1:0] cfg_k_ff, cfg_k_in;
   logic [knn_pkg::CFG_W-1:0] cfg_c_ff, cfg_c_in;
   logic [knn_pkg::CFG_W-1:0] cfg_a_ff, cfg_a_in;
   logic                      csr_wr;
   logic [KEW-1:0]            keff;
   logic [CEW-1:0]            ceff;
   logic [AEW-1:0]            aeff;

   // store and control
   logic signed [knn_pkg::ATTR_BITS-1:0] train_mem [TV_DEPTH];
   logic [knn_pkg::LABEL_W-1:0]          label_mem [MAX_TRAIN];
   logic signed [knn_pkg::ATTR_BITS-1:0] test_ff [MAX_ATTR];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] attr_ff, attr_in;
   logic [ENT_W-1:0] ent_ff, ent_in;
   logic [IDX_W-1:0] att_ff, att_in;
   logic [1:0]       drain_ff, drain_in;
   logic [KW-1:0]    vcnt_ff, vcnt_in;
   logic [CEW-1:0]   ccnt_ff, ccnt_in;
   logic [CLS_W-1:0] win_ff, win_in;
   logic [VCW-1:0]   winv_ff, winv_in;
   logic [VCW-1:0]   votes_ff [MAX_CLASSES];
   logic [VCW-1:0]   votes_in [MAX_CLASSES];
   logic [VCW-1:0]   cur_votes;

   logic             accept, start, store_room, train_we, label_we, test_we;
   logic             att_last, ent_last;
   logic [TV_AW-1:0] wr_addr, rd_addr;

   // scan read stage
   knn_pkg::dist_ctl_type                ctl0, ctl1_ff;
   logic signed [knn_pkg::ATTR_BITS-1:0] rd_ff, tv_ff;
   logic [knn_pkg::LABEL_W-1:0]          lab_rd_ff;
   logic                                 dist_done;
   logic [knn_pkg::DIST_W-1:0]           dist_val;
   logic [knn_pkg::LABEL_W-1:0]          dist_label;

   // neighbour chain
   knn_pkg::cell_ctl_type  cell_ctl;
   knn_pkg::cell_data_type cell_q [MAX_K];
   logic                   cell_less [MAX_K];

   // effective registers, zero counts as one, clamped at the maxima
   always_comb begin
      if (cfg_k_ff == '0) keff = KEW'(1);
      else if (cfg_k_ff > MAX_K) keff = KEW'(MAX_K);
      else keff = KEW'(cfg_k_ff);
      if (cfg_c_ff == '0) ceff = CEW'(1);
      else if (cfg_c_ff > MAX_CLASSES) ceff = CEW'(MAX_CLASSES);
      else ceff = CEW'(cfg_c_ff);
      if (cfg_a_ff == '0) aeff = AEW'(1);
      else if (cfg_a_ff > MAX_ATTR) aeff = AEW'(MAX_ATTR);
      else aeff = AEW'(cfg_a_ff);
   end

   // apb register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_k_in = cfg_k_ff;
      cfg_c_in = cfg_c_ff;
      cfg_a_in = cfg_a_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            knn_pkg::REG_K:       cfg_k_in = csr_pwdata[knn_pkg::CFG_W-1:0];
            knn_pkg::REG_CLASSES: cfg_c_in = csr_pwdata[knn_pkg::CFG_W-1:0];
            knn_pkg::REG_ATTRS:   cfg_a_in = csr_pwdata[knn_pkg::CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         knn_pkg::REG_K:       csr_prdata = knn_pkg::CSR_DATA_W'(cfg_k_ff);
         knn_pkg::REG_CLASSES: csr_prdata = knn_pkg::CSR_DATA_W'(cfg_c_ff);
         knn_pkg::REG_ATTRS:   csr_prdata = knn_pkg::CSR_DATA_W'(cfg_a_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // request decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   assign store_room     = (count_ff < CNT_W'(MAX_TRAIN));
   assign train_we       = accept & (req_chan.op == knn_pkg::OP_TRAIN) & store_room;
   assign label_we       = train_we & req_chan.is_last;
   assign test_we        = accept & (req_chan.op == knn_pkg::OP_TEST);
   assign start          = test_we & req_chan.is_last;
   assign wr_addr        = TV_AW'(count_ff[ENT_W-1:0] * MAX_ATTR + attr_ff);

   // scan addressing, one attribute of one entry per cycle
   assign att_last = (AEW'(att_ff) == aeff - AEW'(1));
   assign ent_last = (CNT_W'(ent_ff) == count_in - CNT_W'(1));
   assign rd_addr  = TV_AW'(ent_ff * MAX_ATTR + att_ff);
   assign ctl0.valid = (state_ff == ST_SCAN);
   assign ctl0.first = (att_ff == '0);
   assign ctl0.last  = att_last;

   assign cur_votes = votes_ff[CLS_W'(ccnt_ff)];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      attr_in  = attr_ff;
      ent_in   = ent_ff;
      att_in   = att_ff;
      drain_in = drain_ff;
      vcnt_in  = vcnt_ff;
      ccnt_in  = ccnt_ff;
      win_in   = win_ff;
      winv_in  = winv_ff;
      votes_in = votes_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.op) inside
                  knn_pkg::OP_CLEAR: begin
                     count_in = '0;
                     attr_in  = '0;
                  end
                  knn_pkg::OP_TRAIN, knn_pkg::OP_TEST: begin
                     if (!req_chan.is_last) begin
                        if (attr_ff < IDX_W'(MAX_ATTR - 1)) attr_in = attr_ff + IDX_W'(1);
                     end else begin
                        attr_in = '0;
                        if (req_chan.op == knn_pkg::OP_TRAIN && store_room) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (start) begin
                  ent_in  = '0;
                  att_in  = '0;
                  vcnt_in = '0;
                  ccnt_in = '0;
                  win_in  = '0;
                  winv_in = '0;
                  for (int c = 0; c < MAX_CLASSES; c++) votes_in[c] = '0;
                  state_in = (count_ff == '0) ? ST_VOTE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (att_last) begin
               att_in = '0;
               if (ent_last) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  ent_in = ent_ff + ENT_W'(1);
               end
            end else begin
               att_in = att_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // the last read passes ctl1_ff and the distance pipeline registers before it is inserted into the chain
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) state_in = ST_VOTE;
         end
         ST_VOTE: begin
            // the chain shifts towards cell zero, one neighbour votes per cycle
            if (cell_q[0].valid && (cell_q[0].label < ceff)) begin
               votes_in[CLS_W'(cell_q[0].label)] =
                  votes_ff[CLS_W'(cell_q[0].label)] + VCW'(1);
            end
            vcnt_in = vcnt_ff + KW'(1);
            if (vcnt_ff == KW'(MAX_K - 1)) state_in = ST_WIN;
         end
         ST_WIN: begin
            // strictly greater keeps the lowest class on a tie
            if (cur_votes > winv_ff) begin
               win_in  = CLS_W'(ccnt_ff);
               winv_in = cur_votes;
            end
            ccnt_in = ccnt_ff + CEW'(1);
            if (ccnt_ff == ceff - CEW'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_k_ff <= knn_pkg::CFG_W'(1);
         cfg_c_ff <= knn_pkg::CFG_W'(2);
         cfg_a_ff <= knn_pkg::CFG_W'(1);
         count_ff <= '0;
         attr_ff  <= '0;
         ent_ff   <= '0;
         att_ff   <= '0;
         drain_ff <= '0;
         vcnt_ff  <= '0;
         ccnt_ff  <= '0;
         ctl1_ff  <= '0;
         for (int c = 0; c < MAX_CLASSES; c++) votes_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         cfg_k_ff <= cfg_k_in;
         cfg_c_ff <= cfg_c_in;
         cfg_a_ff <= cfg_a_in;
         count_ff <= count_in;
         attr_ff  <= attr_in;
         ent_ff   <= ent_in;
         att_ff   <= att_in;
         drain_ff <= drain_in;
         vcnt_ff  <= vcnt_in;
         ccnt_ff  <= ccnt_in;
         ctl1_ff  <= ctl0;
         votes_ff <= votes_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      winv_ff <= winv_in;
   end

   // training store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (train_we) train_mem[wr_addr] <= req_chan.attr_value;
      rd_ff <= train_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (label_we) label_mem[count_ff[ENT_W-1:0]] <= req_chan.train_label;
      lab_rd_ff <= label_mem[ent_ff];
   end

   // test vector, read alongside the store
   always_ff @(posedge clock) begin
      if (test_we) test_ff[attr_ff] <= req_chan.attr_value;
      tv_ff <= test_ff[att_ff];
   end

   knn_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl1_ff),
      .train_val (rd_ff),
      .test_val  (tv_ff),
      .label_in  (lab_rd_ff),
      .done      (dist_done),
      .distance  (dist_val),
      .label_out (dist_label)
   );

   assign cell_ctl.clear  = start;
   assign cell_ctl.insert = dist_done;
   assign cell_ctl.shift  = (state_ff == ST_VOTE);

   // sorted chain, nearest in cell zero; only the first k cells take entries
   for (genvar g = 0; g < MAX_K; g++) begin : g_cell
      knn_pkg::cell_data_type prev_d, next_d;
      logic                   prev_l;
      if (g == 0) begin : g_head
         assign prev_d = '0;
         assign prev_l = 1'b0;
      end else begin : g_body
         assign prev_d = cell_q[g-1];
         assign prev_l = cell_less[g-1];
      end
      if (g == MAX_K - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_link
         assign next_d = cell_q[g+1];
      end
      knn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .enable    (KEW'(g) < keff),
         .ins_dist  (dist_val),
         .ins_label (dist_label),
         .prev_data (prev_d),
         .prev_less (prev_l),
         .next_data (next_d),
         .data      (cell_q[g]),
         .less      (cell_less[g])
      );
   end

   // result register
   assign rsp_chan.valid         = (state_ff == ST_DONE);
   assign rsp_chan.class_out     = knn_pkg::LABEL_W'(win_ff);
   assign rsp_chan.winning_votes = knn_pkg::VOTE_W'(winv_ff);
endmodule

FILE: hw/rtl/knn_checker.sv
// knn_checker: port-level checks of the classifier, bound to the top level
// depends on knn_pkg and knn_classifier
module knn_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [knn_pkg::LABEL_W-1:0] class_out,
   input logic [knn_pkg::VOTE_W-1:0]  winning_votes
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(class_out))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   a_no_votes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (winning_votes == '0) |-> (class_out == '0))
      else $error("class without votes");

   a_vote_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (winning_votes <= knn_pkg::VOTE_W'(16)))
      else $error("more votes than neighbours");
endmodule

bind knn_classifier knn_checker u_knn_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .class_out     (rsp_chan.class_out),
   .winning_votes (rsp_chan.winning_votes)
);

FILE: dv/tb_knn_classifier.sv
// tb_knn_classifier: self-checking bench for the k-nearest-neighbour classifier
// needs knn_pkg, knn_if and the knn_classifier rtl; predicts results, rows may give them
module tb_knn_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_TRAIN    = 1024;
   localparam int N_ATTR     = 16;
   localparam int N_K        = 16;
   localparam int N_CLASS    = 16;
   localparam int CYCLE_CAP  = 3000000;
   localparam int N_RANDOM   = 480;

   typedef struct packed {
      logic [knn_pkg::LABEL_W-1:0] cls;
      logic [knn_pkg::VOTE_W-1:0]  votes;
   } verdict_type;

   typedef struct {
      knn_pkg::op_type op;
      shortint         val;
      logic [3:0]      lab;
      bit              last;
      bit              typed;     // expected verdict given in the row
      verdict_type     verdict;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [knn_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [knn_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   knn_req_if req_chan ();
   knn_rsp_if rsp_chan ();

   knn_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the classifier state
   shortint     train_mem [N_TRAIN][N_ATTR];
   logic [3:0]  train_lab [N_TRAIN];
   logic [15:0] train_seen [N_TRAIN];   // slots ever written, per entry
   shortint     probe_vec [N_ATTR];
   logic [15:0] probe_seen;
   int          stored;
   int          slot;
   logic [4:0]  k_reg, cls_reg, attr_reg;

   verdict_type verdict_q [$];
   int          mismatches;
   int          cycles;
   int          burst_left;
   int          stall_pct;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // cycle cap, ends a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAIL knn_classifier");
         $finish;
      end
   end

   // receiver with its own stall pattern, changed per phase
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic int clamp_cfg(logic [4:0] v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   function automatic logic [15:0] attr_mask();
      return 16'((32'd1 << clamp_cfg(attr_reg, N_ATTR)) - 1);
   endfunction

   // nearest-neighbour vote over the shadow store
   function automatic verdict_type vote_nearest();
      int                 keff, ceff, aeff, kept, p;
      longint unsigned    near_dist [N_K];
      logic [3:0]         near_lab [N_K];
      int                 tally [N_CLASS];
      longint unsigned    d;
      longint             diff;
      verdict_type        v;
      keff = clamp_cfg(k_reg, N_K);
      ceff = clamp_cfg(cls_reg, N_CLASS);
      aeff = clamp_cfg(attr_reg, N_ATTR);
      kept = 0;
      foreach (tally[c]) tally[c] = 0;
      for (int e = 0; e < stored; e++) begin
         d = 0;
         for (int j = 0; j < aeff; j++) begin
            diff = longint'(train_mem[e][j]) - longint'(probe_vec[j]);
            d += longint'(diff * diff);
         end
         // strict compare: equal distance keeps the earlier entry
         p = 0;
         while (p < kept && !(d < near_dist[p])) p++;
         if (p < keff) begin
            if (kept < keff) kept++;
            for (int q = kept - 1; q > p; q--) begin
               near_dist[q] = near_dist[q-1];
               near_lab[q]  = near_lab[q-1];
            end
            near_dist[p] = d;
            near_lab[p]  = train_lab[e];
         end
      end
      for (int i = 0; i < kept; i++)
         if (near_lab[i] < ceff) tally[near_lab[i]]++;
      v = '0;
      for (int c = 0; c < ceff; c++)
         if (tally[c] > v.votes) begin
            v.votes = 5'(tally[c]);
            v.cls   = 4'(c);
         end
      return v;
   endfunction

   // applies one accepted transaction, returns 1 with a verdict on a test close
   function automatic bit apply_attr(knn_pkg::op_type op, shortint val, logic [3:0] lab,
                                     bit last, output verdict_type v);
      v = '0;
      case (op)
         knn_pkg::OP_CLEAR: begin
            stored = 0;
            slot   = 0;
            return 0;
         end
         knn_pkg::OP_NOP: return 0;
         knn_pkg::OP_TRAIN: begin
            if (stored < N_TRAIN) begin
               train_mem[stored][slot] = val;
               train_seen[stored][slot] = 1'b1;
            end
         end
         default: begin
            probe_vec[slot] = val;
            probe_seen[slot] = 1'b1;
         end
      endcase
      if (!last) begin
         if (slot < N_ATTR - 1) slot++;
         return 0;
      end
      slot = 0;
      if (op == knn_pkg::OP_TRAIN) begin
         if (stored < N_TRAIN) begin
            train_lab[stored] = lab;
            stored++;
         end
         return 0;
      end
      v = vote_nearest();
      return 1;
   endfunction

   // closing a vector must never make the block read an unwritten slot
   function automatic bit close_allowed(knn_pkg::op_type op);
      logic [15:0] m;
      m = attr_mask();
      if (op == knn_pkg::OP_TRAIN)
         return stored >= N_TRAIN || ((train_seen[stored] | (16'd1 << slot)) & m) == m;
      if (op == knn_pkg::OP_TEST)
         return ((probe_seen | (16'd1 << slot)) & m) == m;
      return 1;
   endfunction

   // send one transaction at the falling edge, in bursts with random gaps
   task automatic send_attr(knn_pkg::op_type op, shortint val, logic [3:0] lab, bit last,
                            bit typed = 0, verdict_type typed_v = '0);
      verdict_type v;
      if (last && !close_allowed(op)) last = 0;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid       = 1'b1;
      req_chan.op          = op;
      req_chan.attr_value  = val;
      req_chan.train_label = lab;
      req_chan.is_last     = last;
      do @(posedge clock); while (!req_chan.ready);
      if (apply_attr(op, val, lab, last, v)) verdict_q.push_back(typed ? typed_v : v);
      @(negedge clock);
   endtask

   task automatic idle_drain();
      req_chan.valid = 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // apb write: setup then access; upper data bits are junk the block ignores
   task automatic csr_write(knn_pkg::reg_index_type idx, logic [4:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = knn_pkg::CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  = {27'($urandom()), value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      case (idx)
         knn_pkg::REG_K:       k_reg    = value;
         knn_pkg::REG_CLASSES: cls_reg  = value;
         knn_pkg::REG_ATTRS:   attr_reg = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [4:0] k, logic [4:0] c, logic [4:0] a);
      idle_drain();
      csr_write(knn_pkg::REG_K, k);
      csr_write(knn_pkg::REG_CLASSES, c);
      csr_write(knn_pkg::REG_ATTRS, a);
      // clear so stored entries are complete for the new attribute count
      send_attr(knn_pkg::OP_CLEAR, shortint'($urandom()), 4'($urandom()), 1'($urandom()));
   endtask

   function automatic shortint rand_value();
      case ($urandom_range(0, 3))
         0:       return shortint'($urandom_range(0, 6)) - 16'sd3;
         1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return shortint'($urandom());
      endcase
   endfunction

   // one vector of the usual length, sometimes shorter or overlong
   task automatic send_vector(knn_pkg::op_type op);
      int         len;
      logic [3:0] lab;
      len = clamp_cfg(attr_reg, N_ATTR);
      case ($urandom_range(0, 9))
         0:       len = $urandom_range(1, len);
         1:       len = len + $urandom_range(1, 3);
         default: ;
      endcase
      lab = 4'($urandom());
      for (int i = 0; i < len; i++)
         send_attr(op, rand_value(), lab, i == len - 1);
   endtask

   task automatic random_phase(int n_items);
      int start;
      start = 0;
      while (start < n_items) begin
         case ($urandom_range(0, 99)) inside
            [0:64]: begin
               send_vector(knn_pkg::OP_TRAIN);
               start += clamp_cfg(attr_reg, N_ATTR);
            end
            [65:89]: begin
               send_vector(knn_pkg::OP_TEST);
               start += clamp_cfg(attr_reg, N_ATTR);
            end
            [90:92]: begin
               send_attr(knn_pkg::OP_CLEAR, rand_value(), 4'($urandom()), 1'($urandom()));
               start++;
            end
            [93:95]: send_attr(knn_pkg::OP_NOP, rand_value(), 4'($urandom()),
                               1'($urandom()));
            default: begin
               // broken sequence: stray attribute of either kind
               send_attr($urandom_range(0, 1) ? knn_pkg::OP_TRAIN : knn_pkg::OP_TEST,
                         rand_value(), 4'($urandom()), 1'($urandom()));
               start++;
            end
         endcase
      end
   endtask

   // result checker
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result class %0d votes %0d",
                        rsp_chan.class_out, rsp_chan.winning_votes);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_chan.class_out !== want.cls || rsp_chan.winning_votes !== want.votes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected class %0d votes %0d, got %0d %0d",
                           want.cls, want.votes, rsp_chan.class_out, rsp_chan.winning_votes);
            end
         end
      end
   end

   // directed rows, reset settings: k=1, classes=2, attributes=1
   stim_row_type directed [] = '{
      '{knn_pkg::OP_TEST,  -16'sd5,   4'd0,  1, 1, '{4'd0, 5'd0}}, // empty store
      '{knn_pkg::OP_TRAIN, 16'sh7fff, 4'd1,  1, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sh8000, 4'd0,  1, 0, '0},
      '{knn_pkg::OP_TEST,  16'sh7fff, 4'd0,  1, 1, '{4'd1, 5'd1}},
      '{knn_pkg::OP_TEST,  16'sh8000, 4'd0,  1, 1, '{4'd0, 5'd1}},
      '{knn_pkg::OP_TRAIN, 16'sd0,    4'd15, 1, 0, '0},
      '{knn_pkg::OP_TEST,  16'sd0,    4'd0,  1, 1, '{4'd0, 5'd0}}, // label beyond class count
      '{knn_pkg::OP_NOP,   16'sd1234, 4'd7,  1, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sd100,  4'd1,  1, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sd100,  4'd0,  1, 0, '0},
      '{knn_pkg::OP_TEST,  16'sd100,  4'd0,  1, 1, '{4'd1, 5'd1}}, // tie keeps earlier entry
      '{knn_pkg::OP_TRAIN, 16'sd4,    4'd2,  0, 0, '0},            // mixed ops share the index
      '{knn_pkg::OP_TEST,  -16'sd9,   4'd0,  1, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sd1,    4'd0,  1, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sd5,    4'd1,  0, 0, '0},            // overlong vector
      '{knn_pkg::OP_TRAIN, 16'sd6,    4'd1,  0, 0, '0},
      '{knn_pkg::OP_TRAIN, 16'sd7,    4'd1,  1, 0, '0},
      '{knn_pkg::OP_TEST,  16'sd5,    4'd0,  1, 0, '0},
      '{knn_pkg::OP_CLEAR, 16'sd0,    4'd0,  0, 0, '0},
      '{knn_pkg::OP_TEST,  16'sd7,    4'd0,  1, 1, '{4'd0, 5'd0}}  // cleared store
   };

   initial begin
      reset              = 1'b1;
      cycles             = 0;
      mismatches         = 0;
      burst_left         = 0;
      stall_pct          = 0;
      stored             = 0;
      slot               = 0;
      probe_seen         = '0;
      k_reg              = 5'd1;
      cls_reg            = 5'd2;
      attr_reg           = 5'd1;
      foreach (train_seen[e]) train_seen[e] = '0;
      req_chan.valid       = 1'b0;
      req_chan.op          = knn_pkg::OP_NOP;
      req_chan.attr_value  = '0;
      req_chan.train_label = '0;
      req_chan.is_last     = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[r])
         send_attr(directed[r].op, directed[r].val, directed[r].lab, directed[r].last,
                   directed[r].typed, directed[r].verdict);

      // widest setting, receiver stalls hard
      stall_pct = 70;
      configure(5'd16, 5'd16, 5'd16);
      random_phase(N_RANDOM / 4);

      // pause until the block has answered everything, then carry on
      idle_drain();
      stall_pct = 0;
      configure(5'd1, 5'd1, 5'd1);
      random_phase(N_RANDOM / 8);

      // zero and overrange register values are clamped
      stall_pct = 30;
      configure(5'd0, 5'd0, 5'd0);
      random_phase(N_RANDOM / 8);
      configure(5'd31, 5'd31, 5'd31);
      random_phase(N_RANDOM / 8);
      configure(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                5'($urandom_range(2, 5)));
      random_phase(N_RANDOM / 4);

      // store full: further training vectors are dropped
      stall_pct = 10;
      configure(5'd16, 5'd4, 5'd1);
      for (int i = 0; i < N_TRAIN + 6; i++)
         send_attr(knn_pkg::OP_TRAIN, rand_value(), 4'($urandom_range(0, 5)), 1);
      for (int i = 0; i < 4; i++)
         send_attr(knn_pkg::OP_TEST, rand_value(), 4'($urandom()), 1);

      configure(5'($urandom_range(1, 8)), 5'($urandom_range(2, 16)),
                5'($urandom_range(1, 3)));
      random_phase(N_RANDOM / 8);

      idle_drain();
      repeat (50) @(negedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("PASS knn_classifier");
      end else begin
         $display("FAIL knn_classifier");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/knn_pkg.sv
hw/rtl/knn_if.sv
hw/rtl/knn_dist.sv
hw/rtl/knn_cell.sv
hw/rtl/knn_classifier.sv
hw/rtl/knn_checker.sv
dv/tb_knn_classifier.sv
